// ===== hw/rtl/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared widths, register indexes and the alpha fade table of the mipmap
// box downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int CH_W       = 8;
  localparam int PAIR_W     = CH_W + 1;
  localparam int PIX_W      = 3 * CH_W;
  localparam int LINE_W     = 3 * PAIR_W;
  localparam int CFG_SIZE_W = 13;
  localparam int LEVEL_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_MIP_LEVEL     = 2'd2
  } reg_index_t;

  localparam logic [CFG_SIZE_W-1:0] RESET_WIDTH  = 13'd256;
  localparam logic [CFG_SIZE_W-1:0] RESET_HEIGHT = 13'd256;
  localparam logic [LEVEL_W-1:0]    RESET_LEVEL  = 4'd1;

  // floor(255 * 1.5^-level)
  function automatic logic [CH_W-1:0] alpha_fade(input logic [LEVEL_W-1:0] level);
    logic [CH_W-1:0] a;
    unique case (level)
      4'd0:    a = 8'd255;
      4'd1:    a = 8'd170;
      4'd2:    a = 8'd113;
      4'd3:    a = 8'd75;
      4'd4:    a = 8'd50;
      4'd5:    a = 8'd33;
      4'd6:    a = 8'd22;
      4'd7:    a = 8'd14;
      4'd8:    a = 8'd9;
      4'd9:    a = 8'd6;
      4'd10:   a = 8'd4;
      4'd11:   a = 8'd2;
      4'd12:   a = 8'd1;
      4'd13:   a = 8'd1;
      default: a = 8'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/mbd_if.sv =====
// ----------------------------------------------------------------------------
// mbd_in_if / mbd_out_if
// Valid/ready channels for source pixels and downsampled pixels.
// ----------------------------------------------------------------------------
interface mbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface mbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output frame_last, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input frame_last, output ready);
endinterface

// ===== hw/rtl/mbd_ram.sv =====
// ----------------------------------------------------------------------------
// mbd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mbd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mipmap_box_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_downsampler_top
// 2x2 box-filter mip level reducer with line store of pair sums.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order at one word per clock, stalling only
// when a block-completing pixel meets an untaken output word. Each aligned 2x2
// block gives one output word in the cycle after its completing pixel. Pair
// sums of even rows live in a MAX_WIDTH/2 x 27 RAM, written at odd columns of
// even rows and read at odd columns of odd rows, as the completing pixel is
// taken. The output word adds the registered lower pair sum to the RAM read
// data, which holds until the next completing pixel. The RAM needs no clearing
// pass after reset. Configuration must be written while idle (not enforced).
module mipmap_box_downsampler_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_SIZE_W-1:0] cfg_data,
  mbd_in_if.sink                         pix_in,
  mbd_out_if.source                      pix_out
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CMP_W      = (COL_W + 1 > CFG_SIZE_W) ? COL_W + 1 : CFG_SIZE_W;

  logic [CFG_SIZE_W-1:0] source_width;
  logic [CFG_SIZE_W-1:0] source_height;
  logic [LEVEL_W-1:0]    mip_level;
  logic [COL_W-1:0]      column_count;
  logic [ROW_W-1:0]      row_count;
  logic [PIX_W-1:0]      held_pixel;

  logic                  out_valid;
  logic [LINE_W-1:0]     sum_q;
  logic [CH_W-1:0]       alpha_q;
  logic                  last_q;

  logic [CMP_W-1:0]      sw, w, w_last, w_even, cc, col_w;
  logic [CFG_SIZE_W-1:0] h, h_last, h_even, rr, row_w;
  logic [COL_W-1:0]      col_eff;
  logic                  last_col, last_row, in_block, col_odd, row_odd, produce;
  logic                  acc, ram_re, ram_we;
  logic [ADDR_W-1:0]     line_addr;
  logic [PAIR_W-1:0]     sr, sg, sb;
  logic [LINE_W-1:0]     line_wdata, line_rdata;
  logic [PAIR_W:0]       tr, tg, tb;
  logic                  fl;

  // size clamping and position
  always_comb begin
    sw     = CMP_W'(source_width);
    if (sw < CMP_W'(2)) w = CMP_W'(2);
    else if (sw > CMP_W'(MAX_WIDTH)) w = CMP_W'(MAX_WIDTH);
    else w = sw;
    w_last = w - CMP_W'(1);
    w_even = {w[CMP_W-1:1], 1'b0};
    cc     = CMP_W'(column_count);
    col_w  = (cc >= w_last) ? w_last : cc;
    col_eff = COL_W'(col_w);
    last_col = (cc >= w_last);

    if (source_height < CFG_SIZE_W'(2)) h = CFG_SIZE_W'(2);
    else if (source_height > CFG_SIZE_W'(MAX_HEIGHT)) h = CFG_SIZE_W'(MAX_HEIGHT);
    else h = source_height;
    h_last = h - CFG_SIZE_W'(1);
    h_even = {h[CFG_SIZE_W-1:1], 1'b0};
    rr     = CFG_SIZE_W'(row_count);
    row_w  = (rr >= h_last) ? h_last : rr;
    last_row = (rr >= h_last);

    in_block = (col_w < w_even) && (row_w < h_even);
    col_odd  = col_w[0];
    row_odd  = row_w[0];
    produce  = in_block && col_odd && row_odd;
    fl = (col_w == w_even - CMP_W'(1)) && (row_w == h_even - CFG_SIZE_W'(1));
  end

  assign pix_in.ready = !produce || !out_valid || pix_out.ready;
  assign acc          = pix_in.valid && pix_in.ready;
  assign ram_re       = acc && produce;
  assign ram_we       = acc && in_block && col_odd && !row_odd;
  assign line_addr    = ADDR_W'(col_eff >> 1);

  always_comb begin
    sr = PAIR_W'(held_pixel[CH_W-1:0])        + PAIR_W'(pix_in.red_in);
    sg = PAIR_W'(held_pixel[2*CH_W-1:CH_W])   + PAIR_W'(pix_in.green_in);
    sb = PAIR_W'(held_pixel[3*CH_W-1:2*CH_W]) + PAIR_W'(pix_in.blue_in);
    line_wdata = {sb, sg, sr};
    tr = (PAIR_W + 1)'(sum_q[PAIR_W-1:0])
       + (PAIR_W + 1)'(line_rdata[PAIR_W-1:0]);
    tg = (PAIR_W + 1)'(sum_q[2*PAIR_W-1:PAIR_W])
       + (PAIR_W + 1)'(line_rdata[2*PAIR_W-1:PAIR_W]);
    tb = (PAIR_W + 1)'(sum_q[3*PAIR_W-1:2*PAIR_W])
       + (PAIR_W + 1)'(line_rdata[3*PAIR_W-1:2*PAIR_W]);
  end

  mbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_addr),
    .wdata (line_wdata),
    .re    (ram_re),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_WIDTH;
      source_height <= RESET_HEIGHT;
      mip_level     <= RESET_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_MIP_LEVEL:     mip_level     <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
    end else if (acc) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : ROW_W'(row_w + CFG_SIZE_W'(1));
      end else begin
        column_count <= col_eff + COL_W'(1);
        row_count    <= ROW_W'(row_w);
      end
      if (in_block && !col_odd) begin
        held_pixel <= {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && produce) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && produce) begin
      sum_q   <= line_wdata;
      alpha_q <= alpha_fade(mip_level);
      last_q  <= fl;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.red_out    = tr[PAIR_W:2];
  assign pix_out.green_out  = tg[PAIR_W:2];
  assign pix_out.blue_out   = tb[PAIR_W:2];
  assign pix_out.alpha_out  = alpha_q;
  assign pix_out.frame_last = last_q;

  // line store is never read and written in one cycle
  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("line store read and write collide");

  // a completing pixel is never taken over a pending word
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (acc && produce) |-> (!out_valid || pix_out.ready))
    else $error("output word overrun");

  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    (acc && produce) |=> out_valid)
    else $error("output word missing after block completion");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the mipmap box downsampler. Pixel frames of many sizes and
// levels stream in under random valid/ready gaps. Every accepted word goes
// through a local 2x2 box-filter predictor. Each result word is checked field
// by field against the oldest expected word. The stimulus has directed frames,
// two frames at the size limits cut short by a resize, and a long run of
// random frames. Some random frames are cut short and get a register (size or
// level) changed mid-level before they are finished.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  localparam int          MAX_WIDTH   = 4096;
  localparam int          CLK_HALF    = 2;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PRINT_CAP   = 100;

  // fade value per level, level 0 in the low byte
  localparam logic [16*8-1:0] FADE_ROM = {
    8'd0, 8'd0, 8'd1, 8'd1, 8'd2, 8'd4, 8'd6, 8'd9,
    8'd14, 8'd22, 8'd33, 8'd50, 8'd75, 8'd113, 8'd170, 8'd255
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } src_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_last;
  } mip_word_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SOURCE_WIDTH;
  logic [CFG_SIZE_W-1:0] cfg_data  = '0;

  mbd_in_if  pix_in_bus ();
  mbd_out_if pix_out_bus ();

  mipmap_box_downsampler_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_bus),
    .pix_out  (pix_out_bus)
  );

  src_pixel_t  pixel_q[$];
  mip_word_t   expected_mips[$];
  int unsigned pixels_queued  = 0;
  int unsigned pixels_taken   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 36;
  int unsigned snk_idle_pct   = 36;
  logic        hold_go        = 1'b0;
  logic        hold_seen      = 1'b0;
  int unsigned hold_left      = 0;

  // shadow registers and predictor state
  logic [CFG_SIZE_W-1:0] cfg_width  = RESET_WIDTH;
  logic [CFG_SIZE_W-1:0] cfg_height = RESET_HEIGHT;
  logic [LEVEL_W-1:0]    cfg_level  = RESET_LEVEL;
  int unsigned           col_pos    = 0;
  int unsigned           row_pos    = 0;
  src_pixel_t            held_pixel = '0;
  logic [LINE_W-1:0]     pair_line [0:MAX_WIDTH/2-1];

  always #(CLK_HALF) clk = ~clk;

  function automatic int unsigned eff_size(input logic [CFG_SIZE_W-1:0] v,
                                           input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, col, row;
    w   = eff_size(cfg_width, MAX_WIDTH);
    h   = eff_size(cfg_height, MAX_HEIGHT);
    col = (col_pos >= w - 1) ? w - 1 : col_pos;
    row = (row_pos >= h - 1) ? h - 1 : row_pos;
    return (h - 1 - row) * w + (w - col);
  endfunction

  function automatic void downsample_pixel(input src_pixel_t px);
    int unsigned      w, h, w_even, h_even, col, row;
    logic [PAIR_W-1:0] sum_r, sum_g, sum_b;
    logic [LINE_W-1:0] upper;
    logic [9:0]        tot_r, tot_g, tot_b;
    mip_word_t         res;
    w      = eff_size(cfg_width, MAX_WIDTH);
    h      = eff_size(cfg_height, MAX_HEIGHT);
    w_even = w - (w % 2);
    h_even = h - (h % 2);
    col    = (col_pos >= w - 1) ? w - 1 : col_pos;
    row    = (row_pos >= h - 1) ? h - 1 : row_pos;
    if (col < w_even && row < h_even) begin
      if (col % 2 == 0) begin
        held_pixel = px;
      end else begin
        sum_r = held_pixel.red + px.red;
        sum_g = held_pixel.green + px.green;
        sum_b = held_pixel.blue + px.blue;
        if (row % 2 == 0) begin
          pair_line[col / 2] = {sum_b, sum_g, sum_r};
        end else begin
          upper          = pair_line[col / 2];
          tot_r          = sum_r + upper[PAIR_W-1:0];
          tot_g          = sum_g + upper[2*PAIR_W-1:PAIR_W];
          tot_b          = sum_b + upper[3*PAIR_W-1:2*PAIR_W];
          res.red        = tot_r[9:2];
          res.green      = tot_g[9:2];
          res.blue       = tot_b[9:2];
          res.alpha      = FADE_ROM[cfg_level*8 +: 8];
          res.frame_last = (col == w_even - 1) && (row == h_even - 1);
          expected_mips.push_back(res);
        end
      end
    end
    if (col == w - 1) begin
      col_pos = 0;
      row_pos = (row == h - 1) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // sender
  always @(posedge clk) begin : feed
    src_pixel_t px;
    if (rst) begin
      pix_in_bus.valid <= 1'b0;
    end else if (!pix_in_bus.valid || pix_in_bus.ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        px = pixel_q.pop_front();
        pix_in_bus.valid    <= 1'b1;
        pix_in_bus.red_in   <= px.red;
        pix_in_bus.green_in <= px.green;
        pix_in_bus.blue_in  <= px.blue;
      end else begin
        pix_in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pix_out_bus.ready <= 1'b0;
      hold_seen         <= hold_go;
      hold_left         <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen         <= hold_go;
      hold_left         <= LONG_HOLD;
      pix_out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left         <= hold_left - 1;
      pix_out_bus.ready <= 1'b0;
    end else begin
      pix_out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_in_bus.valid && pix_in_bus.ready) begin
      downsample_pixel({pix_in_bus.red_in, pix_in_bus.green_in, pix_in_bus.blue_in});
      pixels_taken++;
    end
  end

  always @(posedge clk) begin : check_out
    mip_word_t want;
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      if (expected_mips.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = expected_mips.pop_front();
        check_field("red", pix_out_bus.red_out, want.red);
        check_field("green", pix_out_bus.green_out, want.green);
        check_field("blue", pix_out_bus.blue_out, want.blue);
        check_field("alpha", pix_out_bus.alpha_out, want.alpha);
        check_field("frame_last", {7'd0, pix_out_bus.frame_last}, {7'd0, want.frame_last});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_pixel(input src_pixel_t px);
    pixel_q.push_back(px);
    pixels_queued++;
  endtask

  task automatic push_random(input int unsigned n);
    src_pixel_t px;
    repeat (n) begin
      px = $urandom;
      if ($urandom_range(7) == 0) px.red   = $urandom_range(1) ? 8'hff : 8'h00;
      if ($urandom_range(7) == 0) px.green = $urandom_range(1) ? 8'hff : 8'h00;
      if ($urandom_range(7) == 0) px.blue  = $urandom_range(1) ? 8'hff : 8'h00;
      push_pixel(px);
    end
  endtask

  // wait until every word is taken and every result has come
  task automatic settle();
    while (pixels_taken != pixels_queued || expected_mips.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_SIZE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SOURCE_WIDTH:  cfg_width  = data;
      REG_SOURCE_HEIGHT: cfg_height = data;
      REG_MIP_LEVEL:     cfg_level  = data[LEVEL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_SIZE_W-1:0] w, input logic [CFG_SIZE_W-1:0] h,
                           input logic [CFG_SIZE_W-1:0] level);
    settle();
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_MIP_LEVEL, level);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned pick_size(input int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(1);
    if (r < 12) return $urandom_range(3 * top, top + 1);
    return $urandom_range(top, 2);
  endfunction

  initial begin : stimulus
    int unsigned random_pixels;
    int unsigned iter;
    int unsigned n;
    pix_in_bus.valid    = 1'b0;
    pix_in_bus.red_in   = '0;
    pix_in_bus.green_in = '0;
    pix_in_bus.blue_in  = '0;
    pix_out_bus.ready   = 1'b0;
    random_pixels       = 0;
    iter                = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // saturated block, full alpha
    configure(2, 2, 0);
    repeat (4) push_pixel({8'd255, 8'd255, 8'd255});

    // odd trailing column and row, zero alpha
    configure(3, 3, 15);
    for (int i = 0; i < 9; i++) begin
      if (i % 2) push_pixel({8'd255, 8'd0, 8'd255});
      else push_pixel({8'd0, 8'd255, 8'd0});
    end

    // width shrinks mid-row, below the minimum
    configure(6, 2, 14);
    push_random(4);
    settle();
    write_reg(REG_SOURCE_WIDTH, 13'd1);
    cfg_we <= 1'b0;
    push_random(pixels_to_frame_end());

    // height shrinks below the current row, to zero
    configure(2, 8, 5);
    push_random(7);
    settle();
    write_reg(REG_SOURCE_HEIGHT, 13'd0);
    cfg_we <= 1'b0;
    push_random(pixels_to_frame_end());

    // size limits, each level finished after a shrink
    configure(13'h1fff, 2, 3);
    push_random(40);
    settle();
    write_reg(REG_SOURCE_WIDTH, 13'd2);
    cfg_we <= 1'b0;
    push_random(pixels_to_frame_end());
    configure(1, 13'h1fff, 9);
    push_random(60);
    settle();
    write_reg(REG_SOURCE_HEIGHT, 13'd2);
    cfg_we <= 1'b0;
    push_random(pixels_to_frame_end());

    while (random_pixels < 1300 || iter < 12) begin
      iter++;
      if (iter == 6) begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end else if (iter == 12) begin
        src_idle_pct <= 36;
        snk_idle_pct <= 36;
      end
      configure(pick_size(24), pick_size(10), $urandom_range(15));
      if (iter == 9) hold_go <= ~hold_go;
      n = pixels_to_frame_end();
      if ($urandom_range(99) < 20) begin
        // cut the level short, change a register, then finish the level
        push_random($urandom_range(n - 1, 1));
        settle();
        case ($urandom_range(2))
          0: write_reg(REG_MIP_LEVEL, $urandom_range(15));
          1: write_reg(REG_SOURCE_HEIGHT, pick_size(10));
          default: write_reg(REG_SOURCE_WIDTH, $urandom_range(eff_size(cfg_width, MAX_WIDTH)));
        endcase
        cfg_we <= 1'b0;
        n = pixels_to_frame_end();
        push_random(n);
        random_pixels += n;
      end else begin
        // sometimes two levels back to back without a pause
        repeat ($urandom_range(2, 1)) begin
          push_random(n);
          random_pixels += n;
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_if.sv
hw/rtl/mbd_ram.sv
hw/rtl/mipmap_box_downsampler_top.sv
sim/tb_top.sv
